@@ hw/rtl/tlbpt_pkg.sv @@
// Shared types and constants for the TLB page translator.
// Used by tlbpt_ctrl, tlbpt_dp and tlb_page_translator; no dependencies.

package tlbpt_pkg;

  localparam int unsigned PAGE_BITS   = 8;
  localparam int unsigned OFFSET_BITS = 8;
  localparam int unsigned VA_W        = PAGE_BITS + OFFSET_BITS;
  localparam int unsigned NUM_PAGES   = 1 << PAGE_BITS;
  localparam int unsigned AGE_W       = 8;
  localparam int unsigned USE_W       = 16;
  localparam int unsigned CNT_W       = 32;

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};
  localparam logic [USE_W-1:0] USE_MAX = {USE_W{1'b1}};

  typedef enum logic [1:0] {
    POL_FIFO = 2'd0,
    POL_LRU  = 2'd1,
    POL_LFU  = 2'd2,
    POL_MFU  = 2'd3
  } policy_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_RESOLVE,
    ST_SCAN,
    ST_INSERT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic resolve;
    logic scan;
    logic insert;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic need_scan;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

@@ hw/rtl/tlbpt_ctrl.sv @@
// Sequencing state machine for the TLB page translator.
// Depends on tlbpt_pkg; drives commands into tlbpt_dp.

module tlbpt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tlbpt_pkg::status_t status_i,
  output tlbpt_pkg::cmd_t    cmd_o
);

  tlbpt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlbpt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tlbpt_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tlbpt_pkg::ST_LOOKUP;
      end
      tlbpt_pkg::ST_LOOKUP: state_d = tlbpt_pkg::ST_RESOLVE;
      tlbpt_pkg::ST_RESOLVE: begin
        if (status_i.hit) state_d = tlbpt_pkg::ST_EMIT;
        else if (status_i.need_scan) state_d = tlbpt_pkg::ST_SCAN;
        else state_d = tlbpt_pkg::ST_INSERT;
      end
      tlbpt_pkg::ST_SCAN: begin
        if (status_i.scan_done) state_d = tlbpt_pkg::ST_INSERT;
      end
      tlbpt_pkg::ST_INSERT: state_d = tlbpt_pkg::ST_EMIT;
      tlbpt_pkg::ST_EMIT: begin
        if (status_i.out_free) state_d = tlbpt_pkg::ST_IDLE;
      end
      default: state_d = tlbpt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      tlbpt_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      tlbpt_pkg::ST_LOOKUP:  cmd_o.lookup  = 1'b1;
      tlbpt_pkg::ST_RESOLVE: cmd_o.resolve = 1'b1;
      tlbpt_pkg::ST_SCAN:    cmd_o.scan    = 1'b1;
      tlbpt_pkg::ST_INSERT:  cmd_o.insert  = 1'b1;
      tlbpt_pkg::ST_EMIT:    cmd_o.emit    = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ hw/rtl/tlbpt_dp.sv @@
// Datapath of the TLB page translator: TLB entries, page table, counters, output register.
// Depends on tlbpt_pkg; commanded by tlbpt_ctrl.

module tlbpt_dp #(
  parameter int unsigned TLB_ENTRIES = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tlbpt_pkg::cmd_t                   cmd_i,
  output tlbpt_pkg::status_t                status_o,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_wdata_i,
  input  logic [tlbpt_pkg::VA_W-1:0]        virtual_address_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tlbpt_pkg::VA_W-1:0]        physical_address_o,
  output logic [tlbpt_pkg::PAGE_BITS-1:0]   frame_index_o,
  output logic                              tlb_hit_o,
  output logic                              page_fault_o,
  output logic [tlbpt_pkg::CNT_W-1:0]       hit_total_o,
  output logic [tlbpt_pkg::CNT_W-1:0]       miss_total_o,
  output logic [tlbpt_pkg::CNT_W-1:0]       fault_total_o
);

  localparam int unsigned IDX_W = $clog2(TLB_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);
  localparam int unsigned PB = tlbpt_pkg::PAGE_BITS;
  localparam int unsigned OB = tlbpt_pkg::OFFSET_BITS;

  tlbpt_pkg::policy_e policy_q;

  logic [TLB_ENTRIES-1:0]           valid_q;
  logic [PB-1:0]                    page_q  [TLB_ENTRIES];
  logic [PB-1:0]                    frame_q [TLB_ENTRIES];
  logic [tlbpt_pkg::AGE_W-1:0]      age_q   [TLB_ENTRIES];
  logic [tlbpt_pkg::USE_W-1:0]      use_q   [TLB_ENTRIES];
  logic [IDX_W-1:0]                 ptr_q;

  logic [tlbpt_pkg::NUM_PAGES-1:0]  tv_q;
  logic [PB-1:0]                    tf_mem [tlbpt_pkg::NUM_PAGES];
  logic [PB-1:0]                    tf_rd_q;
  logic                             tvalid_q;
  logic [PB:0]                      next_free_q;

  logic [tlbpt_pkg::CNT_W-1:0]      hit_cnt_q, miss_cnt_q, fault_cnt_q;

  logic [tlbpt_pkg::VA_W-1:0]       va_q;
  logic                             hit_q;
  logic [IDX_W-1:0]                 hit_idx_q;
  logic [PB-1:0]                    cur_frame_q;
  logic                             fault_q;
  logic [IDX_W-1:0]                 victim_q;
  logic [IDX_W-1:0]                 scan_idx_q;
  logic [tlbpt_pkg::USE_W-1:0]      best_key_q;

  logic                             out_valid_q;
  logic [tlbpt_pkg::VA_W-1:0]       out_pa_q;
  logic [PB-1:0]                    out_frame_q;
  logic                             out_hit_q, out_fault_q;
  logic [tlbpt_pkg::CNT_W-1:0]      out_hit_cnt_q, out_miss_cnt_q, out_fault_cnt_q;

  logic [PB-1:0]                    page;
  logic                             match_any;
  logic [IDX_W-1:0]                 match_idx;
  logic                             free_any;
  logic [IDX_W-1:0]                 free_idx;
  logic [PB-1:0]                    frame_sel;
  logic                             fault_now;
  logic [tlbpt_pkg::USE_W-1:0]      scan_key;
  logic                             scan_better;

  assign page = va_q[tlbpt_pkg::VA_W-1:OB];

  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    free_any  = 1'b0;
    free_idx  = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && page_q[i] == page) begin
        match_any = 1'b1;
        match_idx = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign fault_now = !hit_q && !tvalid_q;
  assign frame_sel = hit_q ? frame_q[hit_idx_q] : (tvalid_q ? tf_rd_q : next_free_q[PB-1:0]);

  always_comb begin
    if (policy_q == tlbpt_pkg::POL_LRU) begin
      scan_key = {{(tlbpt_pkg::USE_W - tlbpt_pkg::AGE_W){1'b0}}, age_q[scan_idx_q]};
    end else begin
      scan_key = use_q[scan_idx_q];
    end
    if (scan_idx_q == '0) begin
      scan_better = 1'b1;
    end else if (policy_q == tlbpt_pkg::POL_LFU) begin
      scan_better = scan_key < best_key_q;
    end else begin
      scan_better = scan_key > best_key_q;
    end
  end

  assign status_o.hit       = hit_q;
  assign status_o.need_scan = !free_any && (policy_q != tlbpt_pkg::POL_FIFO);
  assign status_o.scan_done = scan_idx_q == LAST_IDX;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= tlbpt_pkg::POL_FIFO;
    end else if (cfg_we_i) begin
      policy_q <= tlbpt_pkg::policy_e'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) va_q <= virtual_address_i;
    if (cmd_i.lookup) begin
      hit_q     <= match_any;
      hit_idx_q <= match_idx;
      tf_rd_q   <= tf_mem[page];
      tvalid_q  <= tv_q[page];
    end
    if (cmd_i.resolve) begin
      cur_frame_q <= frame_sel;
      fault_q     <= fault_now;
      victim_q    <= free_any ? free_idx : ptr_q;
      scan_idx_q  <= '0;
      if (fault_now) tf_mem[page] <= next_free_q[PB-1:0];
    end
    if (cmd_i.scan) begin
      scan_idx_q <= scan_idx_q + IDX_W'(1);
      if (scan_better) begin
        best_key_q <= scan_key;
        victim_q   <= scan_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      tv_q        <= '0;
      ptr_q       <= '0;
      next_free_q <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      fault_cnt_q <= '0;
    end else begin
      if (cmd_i.resolve) begin
        if (hit_q) begin
          hit_cnt_q <= hit_cnt_q + 1'b1;
        end else begin
          miss_cnt_q <= miss_cnt_q + 1'b1;
          if (policy_q == tlbpt_pkg::POL_FIFO) begin
            ptr_q <= (ptr_q == LAST_IDX) ? '0 : ptr_q + IDX_W'(1);
          end
        end
        if (fault_now) begin
          tv_q[page]  <= 1'b1;
          next_free_q <= next_free_q + 1'b1;
          fault_cnt_q <= fault_cnt_q + 1'b1;
        end
      end
      if (cmd_i.insert) valid_q[victim_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (cmd_i.resolve && valid_q[i]) begin
        if (hit_q && hit_idx_q == IDX_W'(i)) begin
          age_q[i] <= '0;
          if (use_q[i] != tlbpt_pkg::USE_MAX) use_q[i] <= use_q[i] + 1'b1;
        end else if (age_q[i] != tlbpt_pkg::AGE_MAX) begin
          age_q[i] <= age_q[i] + 1'b1;
        end
      end
      if (cmd_i.insert && victim_q == IDX_W'(i)) begin
        page_q[i]  <= page;
        frame_q[i] <= cur_frame_q;
        age_q[i]   <= '0;
        use_q[i]   <= tlbpt_pkg::USE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_pa_q        <= {cur_frame_q, va_q[OB-1:0]};
      out_frame_q     <= cur_frame_q;
      out_hit_q       <= hit_q;
      out_fault_q     <= fault_q;
      out_hit_cnt_q   <= hit_cnt_q;
      out_miss_cnt_q  <= miss_cnt_q;
      out_fault_cnt_q <= fault_cnt_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign physical_address_o = out_pa_q;
  assign frame_index_o      = out_frame_q;
  assign tlb_hit_o          = out_hit_q;
  assign page_fault_o       = out_fault_q;
  assign hit_total_o        = out_hit_cnt_q;
  assign miss_total_o       = out_miss_cnt_q;
  assign fault_total_o      = out_fault_cnt_q;

endmodule

@@ hw/rtl/tlb_page_translator.sv @@
// Top level of the TLB page translator: controller plus datapath.
// Depends on tlbpt_pkg, tlbpt_ctrl and tlbpt_dp.
//
// Usage:
//   Request channel: in_valid_i / in_stall_o with virtual_address_i (page in
//   the upper byte, offset in the lower byte). Result channel: out_valid_o /
//   out_stall_i with physical_address_o, frame_index_o, tlb_hit_o,
//   page_fault_o and the hit, miss and fault totals after this request.
//   cfg_we_i / cfg_wdata_i write the replacement policy (0 FIFO, 1 LRU,
//   2 LFU, 3 MFU); write only while no request is in flight.
//   One request is handled at a time. A TLB hit passes through the lookup,
//   resolve and emit states. A miss adds the insert state, and when no TLB
//   entry is free and the policy is LRU, LFU or MFU, also the victim scan
//   before it, which reads one entry per cycle.
//   Reset clears the TLB and page table valid bits, the counters, the FIFO
//   pointer and the policy (FIFO). A stalled result holds in the output
//   register while the next request is already accepted and processed up to
//   the point of delivery.

module tlb_page_translator #(
  parameter int unsigned TLB_ENTRIES = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [tlbpt_pkg::VA_W-1:0]       virtual_address_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [tlbpt_pkg::VA_W-1:0]       physical_address_o,
  output logic [tlbpt_pkg::PAGE_BITS-1:0]  frame_index_o,
  output logic                             tlb_hit_o,
  output logic                             page_fault_o,
  output logic [tlbpt_pkg::CNT_W-1:0]      hit_total_o,
  output logic [tlbpt_pkg::CNT_W-1:0]      miss_total_o,
  output logic [tlbpt_pkg::CNT_W-1:0]      fault_total_o,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_wdata_i
);

  tlbpt_pkg::cmd_t    cmd;
  tlbpt_pkg::status_t status;

  tlbpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tlbpt_dp #(
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .virtual_address_i  (virtual_address_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .physical_address_o (physical_address_o),
    .frame_index_o      (frame_index_o),
    .tlb_hit_o          (tlb_hit_o),
    .page_fault_o       (page_fault_o),
    .hit_total_o        (hit_total_o),
    .miss_total_o       (miss_total_o),
    .fault_total_o      (fault_total_o)
  );

endmodule
